// File: rtl/core/hfdg_pkg.sv
// Shared types, register indexes and face loop-count function of the halo descriptor generator.
package hfdg_pkg;

    localparam int EXT_W  = 13;
    localparam int HALO_W = 5;
    localparam int COMP_W = 5;
    localparam int CNT_W  = 15;
    localparam int LEN_W  = 17;
    localparam int OFS_W  = 40;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_DIMS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LAYOUT = 3'd1;
    localparam logic [IDX_W-1:0] REG_EXT0   = 3'd2;
    localparam logic [IDX_W-1:0] REG_EXT1   = 3'd3;
    localparam logic [IDX_W-1:0] REG_EXT2   = 3'd4;
    localparam logic [IDX_W-1:0] REG_HALO   = 3'd5;
    localparam logic [IDX_W-1:0] REG_COMP   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_ADV,
        ST_NEXTF,
        ST_OUT
    } hfdg_state_t;

    typedef struct packed {
        logic signed [CNT_W-1:0] c0;
        logic signed [CNT_W-1:0] c1;
        logic signed [CNT_W-1:0] c2;
        logic signed [CNT_W-1:0] bla;
        logic                    bln;
    } face_counts_t;

    // Loop counts of a face and its block length as factor times (n or 1).
    function automatic face_counts_t face_counts(
        input logic [1:0]        dims,
        input logic              fo,
        input logic [2:0]        f,
        input logic [EXT_W-1:0]  e0,
        input logic [EXT_W-1:0]  e1,
        input logic [EXT_W-1:0]  e2,
        input logic [HALO_W-1:0] h,
        input logic [COMP_W-1:0] n
    );
        face_counts_t r;
        logic signed [CNT_W-1:0] hs;
        logic signed [CNT_W-1:0] ns;
        logic signed [CNT_W-1:0] d0;
        logic signed [CNT_W-1:0] d1;
        logic signed [CNT_W-1:0] d2;
        logic [1:0] dim;
        hs  = $signed({10'b0, h});
        ns  = $signed({10'b0, n});
        d0  = $signed({2'b0, e0}) - hs - hs;
        d1  = $signed({2'b0, e1}) - hs - hs;
        d2  = $signed({2'b0, e2}) - hs - hs;
        dim = f[2:1];
        r.c0  = 15'sd1;
        r.c1  = 15'sd1;
        r.c2  = 15'sd1;
        r.bla = hs;
        r.bln = 1'b1;
        unique case (dims)
            2'd0, 2'd1:
            begin
                if (fo)
                begin
                    r.c0  = ns;
                    r.bln = 1'b0;
                end
            end
            2'd2:
            begin
                if (!fo)
                begin
                    if (dim == 2'd0)
                    begin
                        r.c0  = hs;
                        r.bla = d1;
                    end
                    else
                    begin
                        r.c0 = d0;
                    end
                end
                else if (dim == 2'd0)
                begin
                    r.c0  = ns;
                    r.c1  = d1;
                    r.bln = 1'b0;
                end
                else
                begin
                    r.c0  = ns;
                    r.c1  = hs;
                    r.bla = d0;
                    r.bln = 1'b0;
                end
            end
            default:
            begin
                if (!fo)
                begin
                    if (dim == 2'd0)
                    begin
                        r.c0  = hs;
                        r.c1  = d1;
                        r.bla = d2;
                    end
                    else if (dim == 2'd1)
                    begin
                        r.c0  = d0;
                        r.c1  = hs;
                        r.bla = d2;
                    end
                    else
                    begin
                        r.c0 = d0;
                        r.c1 = d1;
                    end
                end
                else
                begin
                    r.c0  = ns;
                    r.bln = 1'b0;
                    if (dim == 2'd0)
                    begin
                        r.c1 = d2;
                        r.c2 = d1;
                    end
                    else if (dim == 2'd1)
                    begin
                        r.c1  = d2;
                        r.c2  = hs;
                        r.bla = d0;
                    end
                    else
                    begin
                        r.c1  = d1;
                        r.c2  = hs;
                        r.bla = d0;
                    end
                end
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/halo_face_descriptor_generator.sv
// Halo exchange block descriptor generator: top level with offset sequencer and shared MAC.
//
// Use: each transaction on the input channel (in_valid, in_stall, restart) asks for
// the next block descriptor; restart=1 begins again at face 0, block 0. Each input
// transaction gives at most one output transaction (out_valid, out_stall) carrying
// face_index, block_length, send_offset, recv_offset, face_done and all_done. When
// every face is empty no descriptor comes out.
// Configuration is written on cfg_valid/cfg_ready with cfg_index and cfg_data. The user
// writes it only while the block is idle (not enforced); cfg_ready is always high.
// Steps: each face is tried in turn (up to 8 tries); the shared multiply-accumulate
// unit then forms the send and then the receive offset (a load plus three Horner
// steps each); the counters are updated; after the last block of a face the next
// faces are searched for a non-empty one (up to 5); and the output register is
// loaded. in_stall is high from acceptance until that load, so one item is in work
// at a time.
// The output register lets the next item be accepted while a result waits; if the
// receiver stalls and the register is still full, the sequencer holds its result.
// Reset returns the registers to their defaults (3 dimensions, C layout, extents
// 64, halo 1, one component) and the counters to face 0, block 0.
module halo_face_descriptor_generator
    import hfdg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     restart,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               face_index,
    output logic [LEN_W-1:0]         block_length,
    output logic [OFS_W-1:0]         send_offset,
    output logic [OFS_W-1:0]         recv_offset,
    output logic                     face_done,
    output logic                     all_done
);

    // configuration registers
    logic [1:0]        dims_reg;
    logic              fo_reg;
    logic [EXT_W-1:0]  ext0_reg, ext1_reg, ext2_reg;
    logic [HALO_W-1:0] halo_reg;
    logic [COMP_W-1:0] comp_reg;

    // sequencer state
    hfdg_state_t       state_reg, state_next;
    logic [2:0]        face_reg, face_next;
    logic [EXT_W-1:0]  o_reg, o_next, m_reg, m_next, c_reg, c_next;
    logic [2:0]        try_reg, try_next;
    logic [2:0]        nxt_reg, nxt_next;
    logic [1:0]        k_reg, k_next;
    logic              rcv_reg, rcv_next;
    logic [OFS_W-1:0]  acc_reg, acc_next;
    logic [OFS_W-1:0]  snd_reg, snd_next;
    logic [OFS_W-1:0]  rcvo_reg, rcvo_next;
    logic [LEN_W-1:0]  bl_reg, bl_next;
    logic [2:0]        oface_reg, oface_next;
    logic              fdone_reg, fdone_next;
    logic              adone_reg, adone_next;
    logic signed [CNT_W-1:0] c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;

    // output register
    logic              ov_reg, ov_next;
    logic [2:0]        of_reg;
    logic [LEN_W-1:0]  ol_reg;
    logic [OFS_W-1:0]  os_reg, or_reg;
    logic              ofd_reg, oad_reg;
    logic              load_out;

    logic [1:0]        dims_eff;
    logic [2:0]        nf;
    logic [COMP_W-1:0] n_eff;
    logic              wrap;
    logic [2:0]        face_eff;
    logic [EXT_W-1:0]  o_eff, m_eff, c_eff;
    logic [2:0]        cnt_face;
    face_counts_t      fc;
    logic              in_range;
    logic signed [20:0] bl_prod;
    logic [LEN_W-1:0]  bl_clamp;
    logic              nonempty;

    logic [OFS_W-1:0]  coef_t;
    logic [EXT_W-1:0]  coef_m;
    logic [52:0]       prod;
    logic [EXT_W:0]    c_inc, m_inc, o_inc;

    logic [OFS_W-1:0]  e0w, e1w, e2w, hw, ow, mw, cw;
    logic [OFS_W-1:0]  pa, pb, pc;
    logic              up, snd;
    logic [1:0]        dim;

    function automatic logic [OFS_W-1:0] lo_hi(
        input logic [OFS_W-1:0] e,
        input logic [OFS_W-1:0] x,
        input logic [OFS_W-1:0] hh,
        input logic             s,
        input logic             u
    );
        if (s)
            return u ? (e - hh - hh + x) : (hh + x);
        else
            return u ? (e - hh + x) : x;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);

    assign dims_eff = (dims_reg == 2'd0) ? 2'd1 : dims_reg;
    assign nf       = {dims_eff, 1'b0};
    assign n_eff    = (comp_reg < 5'd2) ? 5'd1 : comp_reg;

    assign wrap     = (face_reg >= nf);
    assign face_eff = wrap ? 3'd0 : face_reg;
    assign o_eff    = wrap ? '0 : o_reg;
    assign m_eff    = wrap ? '0 : m_reg;
    assign c_eff    = wrap ? '0 : c_reg;

    assign cnt_face = (state_reg == ST_NEXTF) ? nxt_reg : face_eff;
    assign fc = face_counts(dims_eff, fo_reg, cnt_face, ext0_reg, ext1_reg, ext2_reg,
                            halo_reg, n_eff);

    assign in_range = ($signed({2'b00, o_eff}) < fc.c0) && ($signed({2'b00, m_eff}) < fc.c1)
                   && ($signed({2'b00, c_eff}) < fc.c2);
    assign nonempty = (fc.c0 > 15'sd0) && (fc.c1 > 15'sd0) && (fc.c2 > 15'sd0);

    assign bl_prod = fc.bla * $signed({1'b0, fc.bln ? n_eff : 5'd1});
    always_comb
    begin
        if (bl_prod < 21'sd0)
            bl_clamp = '0;
        else if (bl_prod > 21'sd131071)
            bl_clamp = {LEN_W{1'b1}};
        else
            bl_clamp = bl_prod[LEN_W-1:0];
    end

    // Horner coefficients: acc = T0, then acc = acc*M + T for steps one to three
    assign e0w = {{(OFS_W-EXT_W){1'b0}}, ext0_reg};
    assign e1w = {{(OFS_W-EXT_W){1'b0}}, ext1_reg};
    assign e2w = {{(OFS_W-EXT_W){1'b0}}, ext2_reg};
    assign hw  = {{(OFS_W-HALO_W){1'b0}}, halo_reg};
    assign ow  = {{(OFS_W-EXT_W){1'b0}}, o_reg};
    assign mw  = {{(OFS_W-EXT_W){1'b0}}, m_reg};
    assign cw  = {{(OFS_W-EXT_W){1'b0}}, c_reg};
    assign up  = face_reg[0];
    assign dim = face_reg[2:1];
    assign snd = !rcv_reg;

    always_comb
    begin
        coef_t = '0;
        coef_m = 13'd1;
        pa     = '0;
        pb     = '0;
        pc     = '0;
        unique case (dims_eff)
            2'd0, 2'd1:
            begin
                if (!fo_reg)
                begin
                    if (k_reg == 2'd0)
                        coef_t = lo_hi(e0w, '0, hw, snd, up);
                    else if (k_reg == 2'd1)
                        coef_m = {8'b0, n_eff};
                end
                else
                begin
                    if (k_reg == 2'd0)
                        coef_t = up ? ow + 40'd1 : ow;
                    else if (k_reg == 2'd1)
                    begin
                        coef_m = ext0_reg;
                        coef_t = lo_hi('0, '0, hw, snd, up);
                    end
                end
            end
            2'd2:
            begin
                if (!fo_reg)
                begin
                    if (dim == 2'd0)
                    begin
                        pa = lo_hi(e0w, ow, hw, snd, up);
                        if (snd && !up)
                            pa = ow + hw;
                        pb = hw;
                    end
                    else
                    begin
                        pa = hw + ow + {39'b0, up};
                        pb = lo_hi('0, '0, hw, snd, up);
                    end
                    unique case (k_reg)
                        2'd0: coef_t = pa;
                        2'd1:
                        begin
                            coef_m = ext1_reg;
                            coef_t = pb;
                        end
                        2'd2: coef_m = {8'b0, n_eff};
                        default: coef_m = 13'd1;
                    endcase
                end
                else
                begin
                    if (dim == 2'd0)
                    begin
                        pa = lo_hi(e0w, '0, hw, snd, up);
                        pb = hw + mw;
                    end
                    else
                    begin
                        pa = hw;
                        pb = lo_hi(e1w, mw, hw, snd, up);
                    end
                    unique case (k_reg)
                        2'd0: coef_t = ow;
                        2'd1:
                        begin
                            coef_m = ext1_reg;
                            coef_t = pb;
                        end
                        2'd2:
                        begin
                            coef_m = ext0_reg;
                            coef_t = pa;
                        end
                        default: coef_m = 13'd1;
                    endcase
                end
            end
            default:
            begin
                if (!fo_reg)
                begin
                    pa = hw + ow;
                    pb = hw + mw;
                    pc = hw;
                    if (dim == 2'd0)
                        pa = lo_hi(e0w, ow, hw, snd, up);
                    else if (dim == 2'd1)
                        pb = lo_hi(e1w, mw, hw, snd, up);
                    else
                        pc = lo_hi(e2w, '0, hw, snd, up);
                    unique case (k_reg)
                        2'd0: coef_t = pa;
                        2'd1:
                        begin
                            coef_m = ext1_reg;
                            coef_t = pb;
                        end
                        2'd2:
                        begin
                            coef_m = ext2_reg;
                            coef_t = pc;
                        end
                        default: coef_m = {8'b0, n_eff};
                    endcase
                end
                else
                begin
                    pa = hw;
                    pc = hw + mw;
                    pb = hw + cw;
                    if (dim == 2'd0)
                        pa = lo_hi(e0w, '0, hw, snd, up);
                    else if (dim == 2'd1)
                        pb = lo_hi(e1w, cw, hw, snd, up);
                    else
                    begin
                        pb = hw + mw;
                        pc = lo_hi(e2w, cw, hw, snd, up);
                    end
                    unique case (k_reg)
                        2'd0: coef_t = ow;
                        2'd1:
                        begin
                            coef_m = ext2_reg;
                            coef_t = pc;
                        end
                        2'd2:
                        begin
                            coef_m = ext1_reg;
                            coef_t = pb;
                        end
                        default:
                        begin
                            coef_m = ext0_reg;
                            coef_t = pa;
                        end
                    endcase
                end
            end
        endcase
    end

    assign prod  = acc_reg * coef_m;
    assign c_inc = {1'b0, c_reg} + 14'd1;
    assign m_inc = {1'b0, m_reg} + 14'd1;
    assign o_inc = {1'b0, o_reg} + 14'd1;

    assign load_out = (state_reg == ST_OUT) && (!ov_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        face_next  = face_reg;
        o_next     = o_reg;
        m_next     = m_reg;
        c_next     = c_reg;
        try_next   = try_reg;
        nxt_next   = nxt_reg;
        k_next     = k_reg;
        rcv_next   = rcv_reg;
        acc_next   = acc_reg;
        snd_next   = snd_reg;
        rcvo_next  = rcvo_reg;
        bl_next    = bl_reg;
        oface_next = oface_reg;
        fdone_next = fdone_reg;
        adone_next = adone_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        face_next = '0;
                        o_next    = '0;
                        m_next    = '0;
                        c_next    = '0;
                    end
                    try_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (in_range)
                begin
                    face_next  = face_eff;
                    o_next     = o_eff;
                    m_next     = m_eff;
                    c_next     = c_eff;
                    oface_next = face_eff;
                    bl_next    = bl_clamp;
                    c0_next    = fc.c0;
                    c1_next    = fc.c1;
                    c2_next    = fc.c2;
                    k_next     = '0;
                    rcv_next   = 1'b0;
                    state_next = ST_MUL;
                end
                else
                begin
                    o_next = '0;
                    m_next = '0;
                    c_next = '0;
                    if (try_reg == 3'd7)
                    begin
                        // every face empty: drop the request
                        face_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        face_next = face_eff + 3'd1;
                        try_next  = try_reg + 3'd1;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next = (k_reg == 2'd0) ? coef_t : prod[OFS_W-1:0] + coef_t;
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    if (!rcv_reg)
                    begin
                        snd_next = acc_next;
                        rcv_next = 1'b1;
                    end
                    else
                    begin
                        rcvo_next  = acc_next;
                        state_next = ST_ADV;
                    end
                end
            end
            ST_ADV:
            begin
                fdone_next = 1'b0;
                adone_next = 1'b0;
                nxt_next   = face_reg + 3'd1;
                state_next = ST_OUT;
                c_next     = c_inc[EXT_W-1:0];
                if ($signed({1'b0, c_inc}) >= c2_reg)
                begin
                    c_next = '0;
                    m_next = m_inc[EXT_W-1:0];
                    if ($signed({1'b0, m_inc}) >= c1_reg)
                    begin
                        m_next = '0;
                        o_next = o_inc[EXT_W-1:0];
                        if ($signed({1'b0, o_inc}) >= c0_reg)
                        begin
                            o_next     = '0;
                            fdone_next = 1'b1;
                            state_next = ST_NEXTF;
                        end
                    end
                end
            end
            ST_NEXTF:
            begin
                // search for the next non-empty face, one per cycle
                if (nxt_reg >= nf)
                begin
                    adone_next = 1'b1;
                    face_next  = '0;
                    state_next = ST_OUT;
                end
                else if (nonempty)
                begin
                    face_next  = nxt_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    nxt_next = nxt_reg + 3'd1;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (load_out)
            ov_next = 1'b1;
        else if (ov_reg && !out_stall)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            face_reg  <= '0;
            o_reg     <= '0;
            m_reg     <= '0;
            c_reg     <= '0;
            try_reg   <= '0;
            nxt_reg   <= '0;
            k_reg     <= '0;
            rcv_reg   <= 1'b0;
            fdone_reg <= 1'b0;
            adone_reg <= 1'b0;
            ov_reg    <= 1'b0;
            dims_reg  <= 2'd3;
            fo_reg    <= 1'b0;
            ext0_reg  <= 13'd64;
            ext1_reg  <= 13'd64;
            ext2_reg  <= 13'd64;
            halo_reg  <= 5'd1;
            comp_reg  <= 5'd1;
        end
        else
        begin
            state_reg <= state_next;
            face_reg  <= face_next;
            o_reg     <= o_next;
            m_reg     <= m_next;
            c_reg     <= c_next;
            try_reg   <= try_next;
            nxt_reg   <= nxt_next;
            k_reg     <= k_next;
            rcv_reg   <= rcv_next;
            fdone_reg <= fdone_next;
            adone_reg <= adone_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DIMS:   dims_reg <= cfg_data[1:0];
                    REG_LAYOUT: fo_reg   <= cfg_data[0];
                    REG_EXT0:   ext0_reg <= cfg_data[EXT_W-1:0];
                    REG_EXT1:   ext1_reg <= cfg_data[EXT_W-1:0];
                    REG_EXT2:   ext2_reg <= cfg_data[EXT_W-1:0];
                    REG_HALO:   halo_reg <= cfg_data[HALO_W-1:0];
                    REG_COMP:   comp_reg <= cfg_data[COMP_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        snd_reg   <= snd_next;
        rcvo_reg  <= rcvo_next;
        bl_reg    <= bl_next;
        oface_reg <= oface_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        if (load_out)
        begin
            of_reg  <= oface_reg;
            ol_reg  <= bl_reg;
            os_reg  <= snd_reg;
            or_reg  <= rcvo_reg;
            ofd_reg <= fdone_reg;
            oad_reg <= adone_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign face_index   = of_reg;
    assign block_length = ol_reg;
    assign send_offset  = os_reg;
    assign recv_offset  = or_reg;
    assign face_done    = ofd_reg;
    assign all_done     = oad_reg;

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while sequencer busy");

    a_all_implies_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!all_done || face_done))
        else $error("last block of all faces without last block of face");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (face_index < 3'd6))
        else $error("face index out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("loaded descriptor not presented");
`endif

endmodule

// File: tb/tb_halo_face_descriptor_generator.sv
// Testbench for the halo face descriptor generator: a predicting scoreboard and random traffic.
module tb_halo_face_descriptor_generator;
    import hfdg_pkg::*;

    typedef struct {
        logic [2:0]       face;
        logic [LEN_W-1:0] blen;
        logic [OFS_W-1:0] sofs;
        logic [OFS_W-1:0] rofs;
        logic             fdone;
        logic             adone;
    } descriptor_t;

    class descriptor_scoreboard;
        logic [1:0]  dims;
        logic        fortran;
        logic [12:0] ext0, ext1, ext2;
        logic [4:0]  halo, comps;
        int unsigned face_ctr;
        longint      outer_ctr, middle_ctr, inner_ctr;
        descriptor_t expected_descs[$];
        int          errors;
        int          checked;

        function new();
            dims = 2'd3; fortran = 1'b0;
            ext0 = 13'd64; ext1 = 13'd64; ext2 = 13'd64;
            halo = 5'd1; comps = 5'd1;
            face_ctr = 0; outer_ctr = 0; middle_ctr = 0; inner_ctr = 0;
            errors = 0; checked = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_DIMS:   dims = data[1:0];
                REG_LAYOUT: fortran = data[0];
                REG_EXT0:   ext0 = data[12:0];
                REG_EXT1:   ext1 = data[12:0];
                REG_EXT2:   ext2 = data[12:0];
                REG_HALO:   halo = data[4:0];
                REG_COMP:   comps = data[4:0];
                default:    ;
            endcase
        endfunction

        function longint ncomp();
            return (comps < 2) ? 64'sd1 : longint'(comps);
        endfunction

        function int unsigned ndims();
            return (dims == 2'd0) ? 1 : int'(dims);
        endfunction

        function longint pos_c3(longint a, longint b, longint c);
            longint n, e1, e2;
            n = ncomp(); e1 = ext1; e2 = ext2;
            return c * n + b * e2 * n + a * n * e2 * e1;
        endfunction

        function longint pos_f(longint a, longint b, longint c, longint d);
            longint e0, e1, e2;
            e0 = ext0; e1 = ext1; e2 = ext2;
            return a + b * e0 + c * e0 * e1 + d * e0 * e1 * e2;
        endfunction

        function longint pos_f2(longint a, longint b, longint c);
            longint e0, e1;
            e0 = ext0; e1 = ext1;
            return a + b * e0 + c * e0 * e1;
        endfunction

        function void eval_face(int unsigned f, longint o, longint m, longint c,
                                output longint k0, output longint k1, output longint k2,
                                output longint bl, output longint s, output longint r);
            longint e0, e1, e2, h, n, bd, bw;
            bit up;
            int unsigned dim;
            e0 = ext0; e1 = ext1; e2 = ext2; h = halo; n = ncomp();
            up = f[0];
            dim = f >> 1;
            k0 = 1; k1 = 1; k2 = 1; bl = 0; s = 0; r = 0;
            case (ndims())
                1:
                begin
                    if (!fortran)
                    begin
                        bl = h * n;
                        s = up ? (e0 - 2 * h) * n : h * n;
                        r = up ? (e0 - h) * n : 0;
                    end
                    else
                    begin
                        k0 = n; bl = h;
                        s = up ? (o + 1) * e0 - 2 * h : h + o * e0;
                        r = up ? (o + 1) * e0 - h : o * e0;
                    end
                end
                2:
                begin
                    bd = e1 * n; bw = h * n;
                    if (!fortran)
                    begin
                        if (dim == 0)
                        begin
                            k0 = h; bl = (e1 - 2 * h) * n;
                            s = up ? (e0 - 2 * h + o) * bd + bw : (o + h) * bd + bw;
                            r = up ? (e0 - h + o) * bd + bw : o * bd + bw;
                        end
                        else
                        begin
                            k0 = e0 - 2 * h; bl = h * n;
                            s = up ? (h + o + 1) * bd - 2 * bw : (h + o) * bd + bw;
                            r = up ? (h + o + 1) * bd - bw : (h + o) * bd;
                        end
                    end
                    else if (dim == 0)
                    begin
                        k0 = n; k1 = e1 - 2 * h; bl = h;
                        s = pos_f2(up ? e0 - 2 * h : h, h + m, o);
                        r = pos_f2(up ? e0 - h : 0, h + m, o);
                    end
                    else
                    begin
                        k0 = n; k1 = h; bl = e0 - 2 * h;
                        s = pos_f2(h, up ? e1 - 2 * h + m : h + m, o);
                        r = pos_f2(h, up ? e1 - h + m : m, o);
                    end
                end
                default:
                begin
                    if (!fortran)
                    begin
                        if (dim == 0)
                        begin
                            k0 = h; k1 = e1 - 2 * h; bl = (e2 - 2 * h) * n;
                            s = pos_c3(up ? e0 - 2 * h + o : h + o, h + m, h);
                            r = pos_c3(up ? e0 - h + o : o, h + m, h);
                        end
                        else if (dim == 1)
                        begin
                            k0 = e0 - 2 * h; k1 = h; bl = (e2 - 2 * h) * n;
                            s = pos_c3(h + o, up ? e1 - 2 * h + m : h + m, h);
                            r = pos_c3(h + o, up ? e1 - h + m : m, h);
                        end
                        else
                        begin
                            k0 = e0 - 2 * h; k1 = e1 - 2 * h; bl = h * n;
                            s = pos_c3(h + o, h + m, up ? e2 - 2 * h : h);
                            r = pos_c3(h + o, h + m, up ? e2 - h : 0);
                        end
                    end
                    else
                    begin
                        if (dim == 0)
                        begin
                            k0 = n; k1 = e2 - 2 * h; k2 = e1 - 2 * h; bl = h;
                            s = pos_f(up ? e0 - 2 * h : h, h + c, h + m, o);
                            r = pos_f(up ? e0 - h : 0, h + c, h + m, o);
                        end
                        else if (dim == 1)
                        begin
                            k0 = n; k1 = e2 - 2 * h; k2 = h; bl = e0 - 2 * h;
                            s = pos_f(h, up ? e1 - 2 * h + c : h + c, h + m, o);
                            r = pos_f(h, up ? e1 - h + c : c, h + m, o);
                        end
                        else
                        begin
                            k0 = n; k1 = e1 - 2 * h; k2 = h; bl = e0 - 2 * h;
                            s = pos_f(h, h + m, up ? e2 - 2 * h + c : h + c, o);
                            r = pos_f(h, h + m, up ? e2 - h + c : c, o);
                        end
                    end
                end
            endcase
        endfunction

        function bit face_has_blocks(int unsigned f);
            longint k0, k1, k2, bl, s, r;
            eval_face(f, 0, 0, 0, k0, k1, k2, bl, s, r);
            return k0 > 0 && k1 > 0 && k2 > 0;
        endfunction

        // Advance the counters for one request and queue the descriptor it yields, if any.
        function void note_request(bit restart_req);
            int unsigned nf, nxt;
            longint k0, k1, k2, bl, s, r;
            bit found, fd, ad;
            descriptor_t d;
            nf = 2 * ndims();
            found = 0; fd = 0; ad = 0;
            if (restart_req)
            begin
                face_ctr = 0; outer_ctr = 0; middle_ctr = 0; inner_ctr = 0;
            end
            for (int t = 0; t < 8 && !found; t++)
            begin
                if (face_ctr >= nf)
                begin
                    face_ctr = 0; outer_ctr = 0; middle_ctr = 0; inner_ctr = 0;
                end
                eval_face(face_ctr, outer_ctr, middle_ctr, inner_ctr, k0, k1, k2, bl, s, r);
                if (outer_ctr < k0 && middle_ctr < k1 && inner_ctr < k2)
                    found = 1;
                else
                begin
                    face_ctr = (face_ctr + 1) & 7;
                    outer_ctr = 0; middle_ctr = 0; inner_ctr = 0;
                end
            end
            if (!found)
            begin
                face_ctr = 0; outer_ctr = 0; middle_ctr = 0; inner_ctr = 0;
                return;
            end
            d.face = face_ctr[2:0];
            d.blen = (bl < 0) ? '0 : ((bl > 131071) ? 17'd131071 : bl[LEN_W-1:0]);
            d.sofs = s[OFS_W-1:0];
            d.rofs = r[OFS_W-1:0];
            inner_ctr++;
            if (inner_ctr >= k2)
            begin
                inner_ctr = 0;
                middle_ctr++;
                if (middle_ctr >= k1)
                begin
                    middle_ctr = 0;
                    outer_ctr++;
                    if (outer_ctr >= k0)
                    begin
                        outer_ctr = 0;
                        fd = 1;
                    end
                end
            end
            if (fd)
            begin
                nxt = face_ctr + 1;
                while (nxt < nf && !face_has_blocks(nxt))
                    nxt++;
                if (nxt >= nf)
                begin
                    ad = 1;
                    face_ctr = 0;
                end
                else
                    face_ctr = nxt;
            end
            d.fdone = fd;
            d.adone = ad;
            expected_descs.push_back(d);
        endfunction

        function void check_descriptor(descriptor_t got);
            descriptor_t e;
            if (expected_descs.size() == 0)
            begin
                report("descriptor with none expected");
                return;
            end
            e = expected_descs.pop_front();
            checked++;
            if (got.face !== e.face)
                report($sformatf("face_index got %0d exp %0d", got.face, e.face));
            if (got.blen !== e.blen)
                report($sformatf("block_length got %0d exp %0d", got.blen, e.blen));
            if (got.sofs !== e.sofs)
                report($sformatf("send_offset got %h exp %h", got.sofs, e.sofs));
            if (got.rofs !== e.rofs)
                report($sformatf("recv_offset got %h exp %h", got.rofs, e.rofs));
            if (got.fdone !== e.fdone)
                report($sformatf("face_done got %b exp %b", got.fdone, e.fdone));
            if (got.adone !== e.adone)
                report($sformatf("all_done got %b exp %b", got.adone, e.adone));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 restart;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           face_index;
    logic [LEN_W-1:0]     block_length;
    logic [OFS_W-1:0]     send_offset;
    logic [OFS_W-1:0]     recv_offset;
    logic                 face_done;
    logic                 all_done;

    descriptor_scoreboard sb = new();
    int  requests_sent;
    int  phases_run;
    bit  quiet;

    halo_face_descriptor_generator u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
        .out_valid(out_valid), .out_stall(out_stall),
        .face_index(face_index), .block_length(block_length),
        .send_offset(send_offset), .recv_offset(recv_offset),
        .face_done(face_done), .all_done(all_done)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Receiver: stall in random bursts.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            hold = pick_gap();
            out_stall = (hold != 0);
            repeat (hold == 0 ? $urandom_range(1, 4) : hold) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        descriptor_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.face = face_index; got.blen = block_length;
            got.sofs = send_offset; got.rofs = recv_offset;
            got.fdone = face_done; got.adone = all_done;
            sb.check_descriptor(got);
        end
    end

    task automatic send_request(bit r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        restart = r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(r);
        requests_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Let the block drain, including a request that yields nothing, before a write.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.expected_descs.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_setting(int d, int fo, int e0, int e1, int e2, int h, int n);
        wait_drained();
        write_reg(REG_DIMS, CFG_W'(d));
        write_reg(REG_LAYOUT, CFG_W'(fo));
        write_reg(REG_EXT0, CFG_W'(e0));
        write_reg(REG_EXT1, CFG_W'(e1));
        write_reg(REG_EXT2, CFG_W'(e2));
        write_reg(REG_HALO, CFG_W'(h));
        write_reg(REG_COMP, CFG_W'(n));
        phases_run++;
    endtask

    task automatic run_requests(int count);
        for (int i = 0; i < count; i++)
            send_request($urandom_range(0, 99) < 4);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; restart = 1'b0;
        requests_sent = 0; phases_run = 0; quiet = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: defaults, restarts, extremes, negative length, empty grid.
        for (int i = 0; i < 6; i++)
            send_request(i == 3);
        send_request(1'b1);
        load_setting(1, 0, 4096, 1, 1, 16, 16);
        run_requests(3);
        load_setting(1, 1, 4096, 1, 1, 16, 16);
        run_requests(4);
        // Negative block length saturates low; zero components taken as one.
        load_setting(2, 0, 100, 2, 1, 3, 0);
        run_requests(4);
        // Every face empty: no descriptor.
        load_setting(3, 0, 1, 1, 1, 16, 1);
        run_requests(2);
        load_setting(0, 1, 8191, 8191, 8191, 31, 31);
        run_requests(3);

        // Random settings with sequences long enough to cross faces.
        while (requests_sent < 650)
        begin
            if ($urandom_range(0, 9) == 0)
                load_setting($urandom_range(0, 3), $urandom_range(0, 1),
                             $urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 8191), $urandom_range(0, 31),
                             $urandom_range(0, 31));
            else
                load_setting($urandom_range(0, 3), $urandom_range(0, 1),
                             $urandom_range(1, 12), $urandom_range(1, 12),
                             $urandom_range(1, 12), $urandom_range(0, 3),
                             $urandom_range(0, 4));
            quiet = ($urandom_range(0, 4) == 0);
            run_requests($urandom_range(15, 50) / 2);
            if (phases_run == 12)
            begin
                in_valid = 1'b0;
                while (sb.expected_descs.size() != 0)
                    @(negedge clk);
            end
            run_requests($urandom_range(8, 25));
        end
        in_valid = 1'b0;
        while (sb.expected_descs.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        $display("Ran %0d requests over %0d register settings; %0d descriptors checked.",
                 requests_sent, phases_run, sb.checked);
        if (sb.errors == 0 && sb.expected_descs.size() == 0)
            $display("tb_halo_face_descriptor_generator: PASS");
        else
            $display("tb_halo_face_descriptor_generator: FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_halo_face_descriptor_generator: FAIL");
        $finish;
    end

endmodule
